// File: rtl/core/apg_pkg.sv
// Package with shared widths, register indexes and the division step helper of the phase generator.
`timescale 1ns / 1ps
`default_nettype none

package apg_pkg;

    localparam int FRAME_SIZE = 512;
    localparam int HALF_FRAME = FRAME_SIZE / 2;
    localparam int PIX_W      = 9;
    localparam int CW         = 12;
    localparam int MW         = CW - 1;
    localparam int DW         = 24;
    localparam int FRAC       = 28;
    localparam int QW         = FRAC + 1;
    localparam int VW         = QW + 1;
    localparam int DIV_N      = QW;
    localparam int COEF_W     = 24;
    localparam int PAIR_W     = 48;
    localparam int RAD_W      = 11;
    localparam int BW         = 40;
    localparam int SW         = 45;
    localparam int PHASE_W    = 8;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PISTON    = 3'd0,
        REG_TILT      = 3'd1,
        REG_POWER     = 3'd2,
        REG_ASTIG     = 3'd3,
        REG_COMA      = 3'd4,
        REG_SPHERICAL = 3'd5,
        REG_RADIUS    = 3'd6
    } t_cfg_idx;

    // One restoring division step: quotient bit on top, new remainder below.
    function automatic logic [DW:0] div_step(input logic [DW-1:0] rem,
                                              input logic [DW-1:0] dv,
                                              input logic dbl);
        logic [DW-1:0] t;
        t = dbl ? {rem[DW-2:0], 1'b0} : rem;
        if (t >= dv) begin
            return {1'b1, t - dv};
        end
        return {1'b0, t};
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/apg_pix_if.sv
// Request channel carrying one pixel position.
`timescale 1ns / 1ps
`default_nettype none

interface apg_pix_if;
    import apg_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_row;
    logic [PIX_W-1:0] pixel_col;

    modport source (output valid, output pixel_row, output pixel_col, input ready);
    modport sink   (input valid, input pixel_row, input pixel_col, output ready);
endinterface

`default_nettype wire

// File: rtl/core/apg_phase_if.sv
// Result channel carrying one phase level and the aperture flag.
`timescale 1ns / 1ps
`default_nettype none

interface apg_phase_if;
    import apg_pkg::*;
    logic               valid;
    logic               ready;
    logic [PHASE_W-1:0] phase;
    logic               in_aperture;

    modport source (output valid, output phase, output in_aperture, input ready);
    modport sink   (input valid, input phase, input in_aperture, output ready);
endinterface

`default_nettype wire

// File: rtl/core/aberration_phase_pattern_generator_core.sv
// Top level of the pipelined aberration phase pattern generator.
`timescale 1ns / 1ps
`default_nettype none

// One pixel request is taken per clock unless the output stalls. Stages A and B center
// the position and test the aperture, the bit-serial divider stages scale it by the
// pupil radius, and stages E to I and the output stage form the polynomial terms,
// the coefficient products and the sum. A stall at the output holds the whole pipeline.
// Registers must be written only while the pipeline is empty; the block does not check.
module aberration_phase_pattern_generator_core
    import apg_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    apg_pix_if.sink               s_req,
    apg_phase_if.source           m_rsp,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [PAIR_W-1:0]      i_cfg_data
);

    logic [COEF_W-1:0] r_piston, r_power, r_spherical;
    logic [PAIR_W-1:0] r_tilt, r_astig, r_coma;
    logic [RAD_W-1:0]  r_rad;
    logic [DW-1:0]     r_rr;
    logic [RAD_W-1:0]  cfg_rad;

    assign cfg_rad = (i_cfg_data[RAD_W-1:0] == '0) ? RAD_W'(1) : i_cfg_data[RAD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_piston    <= '0;
            r_tilt      <= 48'h320000320000;
            r_power     <= '0;
            r_astig     <= '0;
            r_coma      <= '0;
            r_spherical <= '0;
            r_rad       <= RAD_W'(100);
            r_rr        <= DW'(10000);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PISTON:    r_piston    <= i_cfg_data[COEF_W-1:0];
                REG_TILT:      r_tilt      <= i_cfg_data;
                REG_POWER:     r_power     <= i_cfg_data[COEF_W-1:0];
                REG_ASTIG:     r_astig     <= i_cfg_data;
                REG_COMA:      r_coma      <= i_cfg_data;
                REG_SPHERICAL: r_spherical <= i_cfg_data[COEF_W-1:0];
                REG_RADIUS: begin
                    r_rad <= cfg_rad;
                    r_rr  <= DW'(cfg_rad) * DW'(cfg_rad);
                end
                default: ;
            endcase
        end
    end

    logic adv;
    logic r_out_vld;
    assign adv         = !r_out_vld || m_rsp.ready;
    assign s_req.ready = adv;

    // Stage A: centered coordinates.
    logic                 r_a_vld;
    logic signed [CW-1:0] r_a_x, r_a_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (adv) begin
            r_a_vld <= s_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_x <= $signed(CW'(s_req.pixel_col)) - $signed(CW'(HALF_FRAME));
            r_a_y <= $signed(CW'(HALF_FRAME)) - $signed(CW'(s_req.pixel_row));
        end
    end

    // Stage B: magnitudes, squared distance and aperture test.
    logic                 r_b_vld, r_b_sx, r_b_sy, r_b_in;
    logic [MW-1:0]        r_b_ax, r_b_ay;
    logic [DW-1:0]        r_b_d;
    logic [CW-1:0]        ax_full, ay_full;
    logic [DW-1:0]        d_sum;

    always_comb begin
        ax_full = r_a_x[CW-1] ? CW'(-r_a_x) : CW'(r_a_x);
        ay_full = r_a_y[CW-1] ? CW'(-r_a_y) : CW'(r_a_y);
        d_sum   = DW'(ax_full[MW-1:0]) * DW'(ax_full[MW-1:0])
                + DW'(ay_full[MW-1:0]) * DW'(ay_full[MW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (adv) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_sx <= r_a_x[CW-1];
            r_b_sy <= r_a_y[CW-1];
            r_b_ax <= ax_full[MW-1:0];
            r_b_ay <= ay_full[MW-1:0];
            r_b_d  <= d_sum;
            r_b_in <= (d_sum <= r_rr);
        end
    end

    // Divider stages: one quotient bit per stage for u, v and r2.
    logic          r_d_vld [DIV_N];
    logic          r_d_sx  [DIV_N];
    logic          r_d_sy  [DIV_N];
    logic          r_d_in  [DIV_N];
    logic [DW-1:0] r_d_ru  [DIV_N];
    logic [DW-1:0] r_d_rv  [DIV_N];
    logic [DW-1:0] r_d_rr  [DIV_N];
    logic [QW-1:0] r_d_qu  [DIV_N];
    logic [QW-1:0] r_d_qv  [DIV_N];
    logic [QW-1:0] r_d_qr  [DIV_N];
    logic [DW-1:0] rad_ext;

    assign rad_ext = DW'(r_rad);

    for (genvar g = 0; g < DIV_N; g++) begin : g_div
        logic          pv, psx, psy, pin;
        logic [DW-1:0] pru, prv, prr;
        logic [QW-1:0] pqu, pqv, pqr;
        logic [DW:0]   su, sv, sr;

        if (g == 0) begin : g_first
            assign pv  = r_b_vld;
            assign psx = r_b_sx;
            assign psy = r_b_sy;
            assign pin = r_b_in;
            assign pru = DW'(r_b_ax);
            assign prv = DW'(r_b_ay);
            assign prr = r_b_d;
            assign pqu = '0;
            assign pqv = '0;
            assign pqr = '0;
        end else begin : g_next
            assign pv  = r_d_vld[g-1];
            assign psx = r_d_sx[g-1];
            assign psy = r_d_sy[g-1];
            assign pin = r_d_in[g-1];
            assign pru = r_d_ru[g-1];
            assign prv = r_d_rv[g-1];
            assign prr = r_d_rr[g-1];
            assign pqu = r_d_qu[g-1];
            assign pqv = r_d_qv[g-1];
            assign pqr = r_d_qr[g-1];
        end

        assign su = div_step(pru, rad_ext, g != 0);
        assign sv = div_step(prv, rad_ext, g != 0);
        assign sr = div_step(prr, r_rr, g != 0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld[g] <= 1'b0;
            end else if (adv) begin
                r_d_vld[g] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_d_sx[g] <= psx;
                r_d_sy[g] <= psy;
                r_d_in[g] <= pin;
                r_d_ru[g] <= su[DW-1:0];
                r_d_rv[g] <= sv[DW-1:0];
                r_d_rr[g] <= sr[DW-1:0];
                r_d_qu[g] <= {pqu[QW-2:0], su[DW]};
                r_d_qv[g] <= {pqv[QW-2:0], sv[DW]};
                r_d_qr[g] <= {pqr[QW-2:0], sr[DW]};
            end
        end
    end

    // Stage E: signed u, v and the first products.
    logic                 r_e_vld, r_e_in;
    logic signed [VW-1:0] r_e_u, r_e_v, r_e_uu, r_e_vv, r_e_uv, r_e_r2sq;
    logic signed [VW-1:0] e_u, e_v, e_r2;
    logic signed [2*VW-1:0] e_puu, e_pvv, e_puv, e_pr2;

    always_comb begin
        e_u   = r_d_sx[DIV_N-1] ? -$signed(VW'(r_d_qu[DIV_N-1]))
                                :  $signed(VW'(r_d_qu[DIV_N-1]));
        e_v   = r_d_sy[DIV_N-1] ? -$signed(VW'(r_d_qv[DIV_N-1]))
                                :  $signed(VW'(r_d_qv[DIV_N-1]));
        e_r2  = $signed(VW'(r_d_qr[DIV_N-1]));
        e_puu = e_u * e_u;
        e_pvv = e_v * e_v;
        e_puv = e_u * e_v;
        e_pr2 = e_r2 * e_r2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (adv) begin
            r_e_vld <= r_d_vld[DIV_N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e_in   <= r_d_in[DIV_N-1];
            r_e_u    <= e_u;
            r_e_v    <= e_v;
            r_e_uu   <= e_puu[FRAC+VW-1:FRAC];
            r_e_vv   <= e_pvv[FRAC+VW-1:FRAC];
            r_e_uv   <= e_puv[FRAC+VW-1:FRAC];
            r_e_r2sq <= e_pr2[FRAC+VW-1:FRAC];
        end
    end

    // Stage F: eighth power of the radius, astigmatism difference, coma factor.
    localparam int CMW = 34;
    logic                  r_f_vld, r_f_in;
    logic signed [VW-1:0]  r_f_u, r_f_v, r_f_uv, r_f_r2sq, r_f_r2q4;
    logic signed [BW-1:0]  r_f_b5;
    logic signed [CMW-1:0] r_f_cm;
    logic signed [2*VW-1:0] f_p4;

    assign f_p4 = r_e_r2sq * r_e_r2sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (adv) begin
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f_in   <= r_e_in;
            r_f_u    <= r_e_u;
            r_f_v    <= r_e_v;
            r_f_uv   <= r_e_uv;
            r_f_r2sq <= r_e_r2sq;
            r_f_r2q4 <= f_p4[FRAC+VW-1:FRAC];
            r_f_b5   <= BW'(r_e_uu) - BW'(r_e_vv);
            r_f_cm   <= CMW'(r_e_r2sq) * $signed(CMW'(15))
                      - ($signed(CMW'(7)) <<< FRAC);
        end
    end

    // Stage G: remaining basis terms.
    logic                 r_g_vld, r_g_in;
    logic signed [BW-1:0] r_g_b [9];
    logic signed [CMW+VW-1:0] g_pcv, g_pcu;

    assign g_pcv = r_f_cm * r_f_v;
    assign g_pcu = r_f_cm * r_f_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else if (adv) begin
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_g_in   <= r_f_in;
            r_g_b[0] <= $signed(BW'(1)) <<< FRAC;
            r_g_b[1] <= BW'(r_f_u);
            r_g_b[2] <= BW'(r_f_v);
            r_g_b[3] <= BW'(r_f_r2sq) * $signed(BW'(3)) - ($signed(BW'(1)) <<< FRAC);
            r_g_b[4] <= BW'(r_f_uv);
            r_g_b[5] <= r_f_b5;
            r_g_b[6] <= BW'($signed(g_pcv[CMW+VW-1:FRAC]));
            r_g_b[7] <= BW'($signed(g_pcu[CMW+VW-1:FRAC]));
            r_g_b[8] <= ($signed(BW'(31)) <<< FRAC)
                      - BW'(r_f_r2sq) * $signed(BW'(240))
                      + BW'(r_f_r2q4) * $signed(BW'(315));
        end
    end

    // Stage H: coefficient products, kept modulo 2^45.
    logic                     r_h_vld, r_h_in;
    logic [SW-1:0]            r_h_p [9];
    logic signed [COEF_W-1:0] coef [9];

    always_comb begin
        coef[0] = $signed(r_piston);
        coef[1] = $signed(r_tilt[COEF_W-1:0]);
        coef[2] = $signed(r_tilt[PAIR_W-1:COEF_W]);
        coef[3] = $signed(r_power);
        coef[4] = $signed(r_astig[PAIR_W-1:COEF_W]);
        coef[5] = $signed(r_astig[COEF_W-1:0]);
        coef[6] = $signed(r_coma[PAIR_W-1:COEF_W]);
        coef[7] = $signed(r_coma[COEF_W-1:0]);
        coef[8] = $signed(r_spherical);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else if (adv) begin
            r_h_vld <= r_g_vld;
        end
    end

    for (genvar k = 0; k < 9; k++) begin : g_prod
        logic signed [COEF_W+BW-1:0] prod;
        assign prod = coef[k] * r_g_b[k];
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_h_p[k] <= prod[SW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_h_in <= r_g_in;
        end
    end

    // Stage I: partial sums.
    logic          r_i_vld, r_i_in;
    logic [SW-1:0] r_i_s [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_vld <= 1'b0;
        end else if (adv) begin
            r_i_vld <= r_h_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_i_in   <= r_h_in;
            r_i_s[0] <= r_h_p[0] + r_h_p[1] + r_h_p[2];
            r_i_s[1] <= r_h_p[3] + r_h_p[4] + r_h_p[5];
            r_i_s[2] <= r_h_p[6] + r_h_p[7] + r_h_p[8];
        end
    end

    // Output stage: final sum, rounding and wrap.
    logic [SW-1:0]      fin_sum;
    logic [PHASE_W-1:0] r_out_phase;
    logic               r_out_in;

    assign fin_sum = r_i_s[0] + r_i_s[1] + r_i_s[2] + (SW'(1) << (FRAC + 8));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_in    <= r_i_in;
            r_out_phase <= r_i_in ? fin_sum[SW-1:SW-PHASE_W] : '0;
        end
    end

    assign m_rsp.valid       = r_out_vld;
    assign m_rsp.phase       = r_out_phase;
    assign m_rsp.in_aperture = r_out_in;

endmodule

`default_nettype wire

// File: rtl/core/apg_checker.sv
// Port-level checker for the phase generator and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module apg_checker
    import apg_pkg::*;
(
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_req_valid,
    input wire               i_req_ready,
    input wire               i_rsp_valid,
    input wire               i_rsp_ready,
    input wire [PHASE_W-1:0] i_rsp_phase,
    input wire               i_rsp_in_aperture
);

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_in_aperture |-> i_rsp_phase == '0)
        else $error("Phase outside the aperture is not zero.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rsp_valid |-> i_req_ready)
        else $error("Request not taken while the output is empty.");

    a_empty_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_rsp_valid)
        else $error("Result shown right after reset.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_phase))
        else $error("Stalled result changed.");

endmodule

bind aberration_phase_pattern_generator_core apg_checker u_apg_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (s_req.valid),
    .i_req_ready       (s_req.ready),
    .i_rsp_valid       (m_rsp.valid),
    .i_rsp_ready       (m_rsp.ready),
    .i_rsp_phase       (m_rsp.phase),
    .i_rsp_in_aperture (m_rsp.in_aperture)
);

`default_nettype wire
